// File: src/i2cbm_pkg.sv
// Package for the I2C bit-level master: command codes, register indexes and
// the state and result structures shared by the step logic and the top level.
// Depends on nothing.
`default_nettype none

package i2cbm_pkg;

  // Command codes, as carried on the mode field and held while busy.
  localparam logic [2:0] CMD_NONE    = 3'd0;
  localparam logic [2:0] CMD_START   = 3'd1;
  localparam logic [2:0] CMD_STOP    = 3'd2;
  localparam logic [2:0] CMD_SEND    = 3'd3;
  localparam logic [2:0] CMD_READ    = 3'd4;
  localparam logic [2:0] CMD_RECOVER = 3'd5;

  // Configuration register indexes.
  localparam logic REG_DELAY_TICKS   = 1'b0;
  localparam logic REG_STRETCH_LIMIT = 1'b1;

  localparam int DelayW   = 10;
  localparam int StretchW = 16;
  localparam int CfgW     = 16;

  localparam logic [DelayW-1:0]   DELAY_RESET   = 10'd30;
  localparam logic [StretchW-1:0] STRETCH_RESET = 16'd500;

  // Bit counter value that marks the ninth slot (acknowledge or last pulse).
  localparam logic [3:0] LAST_BIT = 4'd8;

  typedef struct packed {
    logic [2:0]          cmd;
    logic [2:0]          phase;
    logic [3:0]          bit_count;
    logic [7:0]          shift_byte;
    logic [DelayW-1:0]   delay_left;
    logic [StretchW-1:0] stretch_left;
    logic                nack_held;
    logic                scl_out;
    logic                sda_out;
    logic                ack_flag;
    logic [7:0]          rx_hold;
  } state_t;

  typedef struct packed {
    logic       scl_release;
    logic       sda_release;
    logic       busy;
    logic       done;
    logic [7:0] rx_byte;
    logic       ack_missing;
  } result_t;

endpackage

`default_nettype wire

// File: src/i2cbm_step.sv
// Next-state logic for one tick of the I2C bit-level master.
// Depends on i2cbm_pkg for the state and result structures.
`default_nettype none

module i2cbm_step (
  input  var i2cbm_pkg::state_t                   cur,
  input  wire logic [i2cbm_pkg::DelayW-1:0]       delay_ticks,
  input  wire logic [i2cbm_pkg::StretchW-1:0]     stretch_limit,
  input  wire logic [2:0]                         mode,
  input  wire logic [7:0]                         tx_byte,
  input  wire logic                               nack_last,
  input  wire logic                               sda_in,
  input  wire logic                               scl_in,
  output i2cbm_pkg::state_t                       nxt,
  output i2cbm_pkg::result_t                      res
);

  logic                               ph_begin;
  logic [2:0]                         ph_next;
  logic                               ph_wait;
  logic                               finish;
  logic [3:0]                         bc_inc;
  logic [i2cbm_pkg::DelayW-1:0]       delay_load;

  assign bc_inc     = cur.bit_count + 4'd1;
  assign delay_load = (delay_ticks == '0) ? i2cbm_pkg::DelayW'(1) : delay_ticks;

  always_comb begin
    nxt      = cur;
    ph_begin = 1'b0;
    ph_next  = 3'd0;
    ph_wait  = 1'b0;
    finish   = 1'b0;

    if (cur.cmd == i2cbm_pkg::CMD_NONE) begin
      if (mode == i2cbm_pkg::CMD_START || mode == i2cbm_pkg::CMD_STOP ||
          mode == i2cbm_pkg::CMD_SEND || mode == i2cbm_pkg::CMD_READ ||
          mode == i2cbm_pkg::CMD_RECOVER) begin
        nxt.cmd       = mode;
        nxt.bit_count = 4'd0;
        ph_begin      = 1'b1;
        ph_next       = 3'd0;
        unique case (mode)
          i2cbm_pkg::CMD_START: begin
            nxt.sda_out = 1'b1; nxt.scl_out = 1'b1; ph_wait = 1'b1;
          end
          i2cbm_pkg::CMD_STOP: begin
            nxt.sda_out = 1'b0; nxt.scl_out = 1'b0;
          end
          i2cbm_pkg::CMD_SEND: begin
            nxt.sda_out    = tx_byte[7];
            nxt.shift_byte = {tx_byte[6:0], 1'b0};
          end
          i2cbm_pkg::CMD_READ: begin
            nxt.nack_held  = nack_last;
            nxt.shift_byte = 8'd0;
            nxt.sda_out    = 1'b1; nxt.scl_out = 1'b1; ph_wait = 1'b1;
          end
          default: begin
            nxt.sda_out = 1'b1; nxt.scl_out = 1'b0;
          end
        endcase
      end
    end else if (cur.stretch_left != '0 && !scl_in) begin
      // Released SCL still held low by a target: keep waiting.
      nxt.stretch_left = cur.stretch_left - i2cbm_pkg::StretchW'(1);
    end else begin
      nxt.stretch_left = '0;
      if (cur.delay_left > i2cbm_pkg::DelayW'(1)) begin
        nxt.delay_left = cur.delay_left - i2cbm_pkg::DelayW'(1);
      end else begin
        ph_begin = 1'b1;
        unique case (cur.cmd)
          i2cbm_pkg::CMD_START: begin
            if (cur.phase == 3'd0) begin
              nxt.sda_out = 1'b0; ph_next = 3'd1;
            end else if (cur.phase == 3'd1) begin
              nxt.scl_out = 1'b0; ph_next = 3'd2;
            end else begin
              finish = 1'b1;
            end
          end
          i2cbm_pkg::CMD_STOP: begin
            if (cur.phase == 3'd0) begin
              nxt.scl_out = 1'b1; ph_next = 3'd1; ph_wait = 1'b1;
            end else if (cur.phase == 3'd1) begin
              nxt.sda_out = 1'b1; ph_next = 3'd2;
            end else begin
              finish = 1'b1;
            end
          end
          i2cbm_pkg::CMD_SEND: begin
            if (cur.phase == 3'd0) begin
              nxt.scl_out = 1'b1; ph_next = 3'd1; ph_wait = 1'b1;
            end else if (cur.phase == 3'd1) begin
              if (cur.bit_count >= i2cbm_pkg::LAST_BIT) nxt.ack_flag = sda_in;
              nxt.scl_out = 1'b0; ph_next = 3'd2;
            end else if (cur.bit_count >= i2cbm_pkg::LAST_BIT) begin
              finish = 1'b1;
            end else begin
              nxt.bit_count = bc_inc;
              if (bc_inc < i2cbm_pkg::LAST_BIT) begin
                nxt.sda_out    = cur.shift_byte[7];
                nxt.shift_byte = {cur.shift_byte[6:0], 1'b0};
              end else begin
                // Release SDA for the target's acknowledge.
                nxt.sda_out = 1'b1;
              end
              ph_next = 3'd0;
            end
          end
          i2cbm_pkg::CMD_READ: begin
            if (cur.phase == 3'd0) begin
              nxt.shift_byte = {cur.shift_byte[6:0], sda_in};
              nxt.scl_out    = 1'b0; ph_next = 3'd1;
            end else if (cur.phase == 3'd1) begin
              if (cur.bit_count < 4'd7) begin
                nxt.bit_count = bc_inc;
                nxt.scl_out   = 1'b1; ph_next = 3'd0; ph_wait = 1'b1;
              end else begin
                nxt.bit_count = i2cbm_pkg::LAST_BIT;
                nxt.sda_out   = cur.nack_held; ph_next = 3'd2;
              end
            end else if (cur.phase == 3'd2) begin
              nxt.scl_out = 1'b1; ph_next = 3'd3; ph_wait = 1'b1;
            end else if (cur.phase == 3'd3) begin
              nxt.scl_out = 1'b0; nxt.sda_out = 1'b1; ph_next = 3'd4;
            end else begin
              nxt.rx_hold = cur.shift_byte;
              finish      = 1'b1;
            end
          end
          i2cbm_pkg::CMD_RECOVER: begin
            if (cur.phase == 3'd0) begin
              nxt.scl_out = 1'b1; ph_next = 3'd1; ph_wait = 1'b1;
            end else if (cur.phase == 3'd1) begin
              if (sda_in || cur.bit_count >= i2cbm_pkg::LAST_BIT) begin
                nxt.sda_out = 1'b0; ph_next = 3'd2;
              end else begin
                nxt.bit_count = bc_inc;
                nxt.scl_out   = 1'b0; ph_next = 3'd0;
              end
            end else if (cur.phase == 3'd2) begin
              nxt.scl_out = 1'b1; ph_next = 3'd3; ph_wait = 1'b1;
            end else if (cur.phase == 3'd3) begin
              nxt.sda_out = 1'b1; ph_next = 3'd4;
            end else begin
              finish = 1'b1;
            end
          end
          default: begin
            finish = 1'b1;
          end
        endcase
      end
    end

    if (finish) begin
      nxt.cmd        = i2cbm_pkg::CMD_NONE;
      nxt.phase      = 3'd0;
      nxt.delay_left = '0;
    end else if (ph_begin) begin
      nxt.phase        = ph_next;
      nxt.delay_left   = delay_load;
      nxt.stretch_left = ph_wait ? stretch_limit : '0;
    end
  end

  always_comb begin
    res.scl_release = nxt.scl_out;
    res.sda_release = nxt.sda_out;
    res.busy        = (nxt.cmd != i2cbm_pkg::CMD_NONE);
    res.done        = finish;
    res.rx_byte     = nxt.rx_hold;
    res.ack_missing = nxt.ack_flag;
  end

endmodule

`default_nettype wire

// File: src/i2c_bit_level_master.sv
// Top level of the I2C bit-level master: configuration registers, the state
// register, the result register and the handshakes. Uses i2cbm_pkg and
// i2cbm_step.
`default_nettype none

// The result is registered: it appears on the output in the cycle after its input transaction.
// Throughput: one transaction per cycle; in_ready stays high while the result
// register is empty or is being taken in the same cycle.
// Reset (synchronous, active high): the state holds both bus lines released, the master is
// idle, delay_ticks is 30 and stretch_limit is 500; no result is pending.
module i2c_bit_level_master (
  input  wire logic        clk,
  input  wire logic        rst,
  // Configuration write port.
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_data,
  // Input channel: one bus tick per transaction.
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  mode,
  input  wire logic [7:0]  tx_byte,
  input  wire logic        nack_last,
  input  wire logic        sda_in,
  input  wire logic        scl_in,
  // Output channel: one result per input transaction.
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             scl_release,
  output logic             sda_release,
  output logic             busy_res,
  output logic             done_res,
  output logic [7:0]       rx_byte,
  output logic             ack_missing
);

  logic [i2cbm_pkg::DelayW-1:0]   delay_ticks;
  logic [i2cbm_pkg::StretchW-1:0] stretch_limit;
  i2cbm_pkg::state_t              st;
  i2cbm_pkg::state_t              st_next;
  i2cbm_pkg::result_t             res_next;
  logic                           in_take;

  // The result register parts the two channels: a new tick is taken whenever
  // the register is free or is emptied in this same cycle.
  assign in_ready = !out_valid || out_ready;
  assign in_take  = in_valid && in_ready;

  // Configuration is to be written only while the master is idle; the block itself
  // does not enforce this, so the registers are simply overwritten.
  always_ff @(posedge clk) begin
    if (rst) begin
      delay_ticks   <= i2cbm_pkg::DELAY_RESET;
      stretch_limit <= i2cbm_pkg::STRETCH_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        i2cbm_pkg::REG_DELAY_TICKS:   delay_ticks   <= cfg_data[i2cbm_pkg::DelayW-1:0];
        i2cbm_pkg::REG_STRETCH_LIMIT: stretch_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  // All the work for one tick happens in the step logic, between the state
  // register and the result register.
  i2cbm_step u_step (
    .cur           (st),
    .delay_ticks   (delay_ticks),
    .stretch_limit (stretch_limit),
    .mode          (mode),
    .tx_byte       (tx_byte),
    .nack_last     (nack_last),
    .sda_in        (sda_in),
    .scl_in        (scl_in),
    .nxt           (st_next),
    .res           (res_next)
  );

  // Bus state advances only on an accepted transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      st.cmd          <= i2cbm_pkg::CMD_NONE;
      st.phase        <= 3'd0;
      st.bit_count    <= 4'd0;
      st.shift_byte   <= 8'd0;
      st.delay_left   <= '0;
      st.stretch_left <= '0;
      st.nack_held    <= 1'b0;
      st.scl_out      <= 1'b1;
      st.sda_out      <= 1'b1;
      st.ack_flag     <= 1'b0;
      st.rx_hold      <= 8'd0;
    end else if (in_take) begin
      st <= st_next;
    end
  end

  // Result register with its valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      scl_release <= res_next.scl_release;
      sda_release <= res_next.sda_release;
      busy_res    <= res_next.busy;
      done_res    <= res_next.done;
      rx_byte     <= res_next.rx_byte;
      ack_missing <= res_next.ack_missing;
    end
  end

  // A finishing tick always leaves the master idle.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && done_res |-> !busy_res)
    else $error("done reported while still busy");

  // An idle master carries no phase and no pending delay.
  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    st.cmd == i2cbm_pkg::CMD_NONE |-> st.phase == 3'd0 && st.delay_left == '0)
    else $error("idle master holds phase or delay");

  // Every accepted tick yields a result in the next cycle.
  a_take_gives_result: assert property (@(posedge clk) disable iff (rst)
    in_take |=> out_valid)
    else $error("accepted tick produced no result");

  // The reported busy flag follows the held command.
  a_busy_matches: assert property (@(posedge clk) disable iff (rst)
    in_take |=> busy_res == (st.cmd != i2cbm_pkg::CMD_NONE))
    else $error("busy flag disagrees with held command");

endmodule

`default_nettype wire

// File: bench/testbench.sv
// Self-checking bench for the I2C bit-level master: a directed table of bus ticks,
// then random command sequences, all checked against a cycle-true behavioural model.
// Depends on i2cbm_pkg and i2c_bit_level_master from the RTL.
`timescale 1ns / 100ps

module testbench;

  // Codes outside the command set; the master must treat them as "no command".
  localparam logic [2:0] MODE_SPARE_6 = 3'd6;
  localparam logic [2:0] MODE_SPARE_7 = 3'd7;

  localparam int SETTLE_PAUSE = 4;        // result register latency plus margin
  localparam int HOLD_CYCLES  = 300;      // long receiver hold-off for back-pressure
  localparam int unsigned CYCLE_LIMIT = 1_000_000;

  // One bus tick as offered on the input channel.
  typedef struct packed {
    logic [2:0] mode;
    logic [7:0] tx;
    logic       nack;
    logic       sda;
    logic       scl;
  } tick_t;

  typedef enum logic { ROW_TICK, ROW_CFG } row_kind_t;

  // A directed row either repeats one tick or writes one register.
  typedef struct packed {
    row_kind_t          kind;
    logic [2:0]         mode;
    logic [7:0]         tx;
    logic               nack;
    logic               sda;
    logic               scl;
    logic [7:0]         reps;
    logic               chk;
    i2cbm_pkg::result_t want;
    logic               cfg_idx;
    logic [15:0]        cfg_val;
  } step_row_t;

  // Line states that can be read straight off the behaviour: an idle master with
  // both lines released, and the first tick of a start condition.
  localparam i2cbm_pkg::result_t LINES_IDLE = '{scl_release: 1'b1, sda_release: 1'b1,
                                                busy: 1'b0, done: 1'b0, rx_byte: 8'h00,
                                                ack_missing: 1'b0};
  localparam i2cbm_pkg::result_t LINES_START = '{scl_release: 1'b1, sda_release: 1'b1,
                                                 busy: 1'b1, done: 1'b0, rx_byte: 8'h00,
                                                 ack_missing: 1'b0};
  localparam tick_t IDLE_TICK = '{mode: i2cbm_pkg::CMD_NONE, tx: 8'h00, nack: 1'b0,
                                  sda: 1'b1, scl: 1'b1};

  localparam int DIR_ROWS = 30;

  // Directed part. Only the first rows carry a typed-in expectation; everything
  // else is checked against the model below. Register rows let the master finish
  // whatever it is doing before the write.
  localparam step_row_t DIR_STEPS [DIR_ROWS] = '{
    // Out of reset, then the two spare codes, then a start at the reset timing.
    '{ROW_TICK, i2cbm_pkg::CMD_NONE,    8'h00, 1'b0, 1'b1, 1'b1, 8'd1,  1'b1,
      LINES_IDLE,  1'b0, 16'd0},
    '{ROW_TICK, MODE_SPARE_6,           8'h00, 1'b0, 1'b1, 1'b1, 8'd1,  1'b1,
      LINES_IDLE,  1'b0, 16'd0},
    '{ROW_TICK, MODE_SPARE_7,           8'hFF, 1'b1, 1'b0, 1'b0, 8'd1,  1'b1,
      LINES_IDLE,  1'b0, 16'd0},
    '{ROW_TICK, i2cbm_pkg::CMD_START,   8'h00, 1'b0, 1'b1, 1'b1, 8'd1,  1'b1,
      LINES_START, 1'b0, 16'd0},
    // A send offered while the start is still running is ignored.
    '{ROW_TICK, i2cbm_pkg::CMD_SEND,    8'hFF, 1'b0, 1'b1, 1'b1, 8'd3,  1'b0,
      LINES_IDLE,  1'b0, 16'd0},
    '{ROW_CFG,  i2cbm_pkg::CMD_NONE,    8'h00, 1'b0, 1'b1, 1'b1, 8'd0,  1'b0,
      LINES_IDLE,  i2cbm_pkg::REG_DELAY_TICKS, 16'd1},
    '{ROW_CFG,  i2cbm_pkg::CMD_NONE,    8'h00, 1'b0, 1'b1, 1'b1, 8'd0,  1'b0,
      LINES_IDLE,  i2cbm_pkg::REG_STRETCH_LIMIT, 16'd3},
    '{ROW_TICK, i2cbm_pkg::CMD_START,   8'h00, 1'b0, 1'b1, 1'b1, 8'd1,  1'b0,
      LINES_IDLE,  1'b0, 16'd0},
    '{ROW_TICK, i2cbm_pkg::CMD_NONE,    8'h00, 1'b0, 1'b1, 1'b1, 8'd6,  1'b0,
      LINES_IDLE,  1'b0, 16'd0},
    // All-ones byte with no acknowledge, then all-zeros byte acknowledged.
    '{ROW_TICK, i2cbm_pkg::CMD_SEND,    8'hFF, 1'b0, 1'b1, 1'b1, 8'd1,  1'b0,
      LINES_IDLE,  1'b0, 16'd0},
    '{ROW_TICK, i2cbm_pkg::CMD_NONE,    8'h00, 1'b0, 1'b1, 1'b1, 8'd40, 1'b0,
      LINES_IDLE,  1'b0, 16'd0},
    '{ROW_TICK, i2cbm_pkg::CMD_SEND,    8'h00, 1'b0, 1'b0, 1'b1, 8'd1,  1'b0,
      LINES_IDLE,  1'b0, 16'd0},
    '{ROW_TICK, i2cbm_pkg::CMD_NONE,    8'h00, 1'b0, 1'b0, 1'b1, 8'd40, 1'b0,
      LINES_IDLE,  1'b0, 16'd0},
    // Read of all ones answered with NACK.
    '{ROW_TICK, i2cbm_pkg::CMD_READ,    8'h00, 1'b1, 1'b1, 1'b1, 8'd1,  1'b0,
      LINES_IDLE,  1'b0, 16'd0},
    '{ROW_TICK, i2cbm_pkg::CMD_NONE,    8'h00, 1'b0, 1'b1, 1'b1, 8'd30, 1'b0,
      LINES_IDLE,  1'b0, 16'd0},
    // Read of all zeros answered with ACK; SCL is held low past the stretch limit.
    '{ROW_TICK, i2cbm_pkg::CMD_READ,    8'h00, 1'b0, 1'b0, 1'b0, 8'd1,  1'b0,
      LINES_IDLE,  1'b0, 16'd0},
    '{ROW_TICK, i2cbm_pkg::CMD_NONE,    8'h00, 1'b0, 1'b0, 1'b0, 8'd6,  1'b0,
      LINES_IDLE,  1'b0, 16'd0},
    '{ROW_TICK, i2cbm_pkg::CMD_NONE,    8'h00, 1'b0, 1'b0, 1'b1, 8'd30, 1'b0,
      LINES_IDLE,  1'b0, 16'd0},
    // Recovery with SDA stuck low: all nine pulses, then the stop sequence.
    '{ROW_TICK, i2cbm_pkg::CMD_RECOVER, 8'h00, 1'b0, 1'b0, 1'b1, 8'd1,  1'b0,
      LINES_IDLE,  1'b0, 16'd0},
    '{ROW_TICK, i2cbm_pkg::CMD_NONE,    8'h00, 1'b0, 1'b0, 1'b1, 8'd40, 1'b0,
      LINES_IDLE,  1'b0, 16'd0},
    // Recovery with SDA already free ends after the first pulse.
    '{ROW_TICK, i2cbm_pkg::CMD_RECOVER, 8'h00, 1'b0, 1'b1, 1'b1, 8'd1,  1'b0,
      LINES_IDLE,  1'b0, 16'd0},
    '{ROW_TICK, i2cbm_pkg::CMD_NONE,    8'h00, 1'b0, 1'b1, 1'b1, 8'd10, 1'b0,
      LINES_IDLE,  1'b0, 16'd0},
    '{ROW_TICK, i2cbm_pkg::CMD_STOP,    8'h00, 1'b0, 1'b1, 1'b1, 8'd1,  1'b0,
      LINES_IDLE,  1'b0, 16'd0},
    '{ROW_TICK, i2cbm_pkg::CMD_NONE,    8'h00, 1'b0, 1'b1, 1'b1, 8'd6,  1'b0,
      LINES_IDLE,  1'b0, 16'd0},
    // A zero delay behaves as one tick; a zero stretch limit never waits for SCL.
    '{ROW_CFG,  i2cbm_pkg::CMD_NONE,    8'h00, 1'b0, 1'b1, 1'b1, 8'd0,  1'b0,
      LINES_IDLE,  i2cbm_pkg::REG_DELAY_TICKS, 16'd0},
    '{ROW_CFG,  i2cbm_pkg::CMD_NONE,    8'h00, 1'b0, 1'b1, 1'b1, 8'd0,  1'b0,
      LINES_IDLE,  i2cbm_pkg::REG_STRETCH_LIMIT, 16'd0},
    // Send with no start before it, SCL held low throughout.
    '{ROW_TICK, i2cbm_pkg::CMD_SEND,    8'hA5, 1'b0, 1'b1, 1'b0, 8'd1,  1'b0,
      LINES_IDLE,  1'b0, 16'd0},
    '{ROW_TICK, i2cbm_pkg::CMD_NONE,    8'h00, 1'b0, 1'b1, 1'b0, 8'd30, 1'b0,
      LINES_IDLE,  1'b0, 16'd0},
    '{ROW_TICK, i2cbm_pkg::CMD_READ,    8'h00, 1'b1, 1'b1, 1'b0, 8'd1,  1'b0,
      LINES_IDLE,  1'b0, 16'd0},
    '{ROW_TICK, i2cbm_pkg::CMD_NONE,    8'h00, 1'b0, 1'b0, 1'b0, 8'd25, 1'b0,
      LINES_IDLE,  1'b0, 16'd0}
  };

  // Clock, reset and the block's ports. Every input has a known value from time 0.
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  mode = i2cbm_pkg::CMD_NONE;
  logic [7:0]  tx_byte = '0;
  logic        nack_last = 1'b0;
  logic        sda_in = 1'b1;
  logic        scl_in = 1'b1;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        scl_release;
  logic        sda_release;
  logic        busy_res;
  logic        done_res;
  logic [7:0]  rx_byte;
  logic        ack_missing;

  // A typed-in expectation travels alongside its transaction, so that it is
  // sampled at exactly the edge at which the tick is accepted.
  logic               lit_on = 1'b0;
  i2cbm_pkg::result_t lit_want = LINES_IDLE;

  int          send_idle_pct = 0;
  int          stall_pct = 0;
  int          hold_asked = 0;
  int          hold_served = 0;
  int          hold_left = 0;
  int          taken = 0;
  int          fail_count = 0;
  int unsigned cycles = 0;

  i2cbm_pkg::result_t expected_lines [$];

  // Behavioural model of the master: configuration, then the state it keeps.
  logic [9:0]  cfg_delay = i2cbm_pkg::DELAY_RESET;
  logic [15:0] cfg_stretch = i2cbm_pkg::STRETCH_RESET;

  logic [2:0]  m_cmd = i2cbm_pkg::CMD_NONE;
  logic [2:0]  m_phase = '0;
  logic [3:0]  m_bits = '0;
  logic [7:0]  m_shift = '0;
  logic [9:0]  m_delay = '0;
  logic [15:0] m_stretch = '0;
  logic        m_nack = 1'b0;
  logic        m_scl = 1'b1;
  logic        m_sda = 1'b1;
  logic        m_ack = 1'b0;
  logic [7:0]  m_rx = '0;

  i2c_bit_level_master DUT (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
  end

  // Enters a bus phase: the hold delay is reloaded (a zero delay counts as one)
  // and, where SCL has just been released, the clock-stretch wait is armed.
  function automatic void open_phase(input logic [2:0] next_phase, input bit wait_scl);
    m_phase   = next_phase;
    m_delay   = (cfg_delay == '0) ? 10'd1 : cfg_delay;
    m_stretch = wait_scl ? cfg_stretch : 16'd0;
  endfunction

  // Moves the running command on by one phase. Returns 0 once the command has
  // nothing further to do.
  function automatic bit next_phase(input logic sda);
    case (m_cmd)
      i2cbm_pkg::CMD_START: begin
        if (m_phase == 3'd0) begin
          m_sda = 1'b0;
          open_phase(3'd1, 1'b0);
          return 1'b1;
        end
        if (m_phase == 3'd1) begin
          m_scl = 1'b0;
          open_phase(3'd2, 1'b0);
          return 1'b1;
        end
        return 1'b0;
      end
      i2cbm_pkg::CMD_STOP: begin
        if (m_phase == 3'd0) begin
          m_scl = 1'b1;
          open_phase(3'd1, 1'b1);
          return 1'b1;
        end
        if (m_phase == 3'd1) begin
          m_sda = 1'b1;
          open_phase(3'd2, 1'b0);
          return 1'b1;
        end
        return 1'b0;
      end
      i2cbm_pkg::CMD_SEND: begin
        if (m_phase == 3'd0) begin
          m_scl = 1'b1;
          open_phase(3'd1, 1'b1);
          return 1'b1;
        end
        if (m_phase == 3'd1) begin
          // The ninth high phase is the acknowledge slot.
          if (m_bits >= i2cbm_pkg::LAST_BIT) m_ack = sda;
          m_scl = 1'b0;
          open_phase(3'd2, 1'b0);
          return 1'b1;
        end
        if (m_bits >= i2cbm_pkg::LAST_BIT) return 1'b0;
        m_bits = m_bits + 4'd1;
        if (m_bits < i2cbm_pkg::LAST_BIT) begin
          m_sda   = m_shift[7];
          m_shift = {m_shift[6:0], 1'b0};
        end else begin
          m_sda = 1'b1;
        end
        open_phase(3'd0, 1'b0);
        return 1'b1;
      end
      i2cbm_pkg::CMD_READ: begin
        if (m_phase == 3'd0) begin
          m_shift = {m_shift[6:0], sda};
          m_scl   = 1'b0;
          open_phase(3'd1, 1'b0);
          return 1'b1;
        end
        if (m_phase == 3'd1) begin
          if (m_bits < 4'd7) begin
            m_bits = m_bits + 4'd1;
            m_scl  = 1'b1;
            open_phase(3'd0, 1'b1);
            return 1'b1;
          end
          m_bits = i2cbm_pkg::LAST_BIT;
          m_sda  = m_nack;
          open_phase(3'd2, 1'b0);
          return 1'b1;
        end
        if (m_phase == 3'd2) begin
          m_scl = 1'b1;
          open_phase(3'd3, 1'b1);
          return 1'b1;
        end
        if (m_phase == 3'd3) begin
          m_scl = 1'b0;
          m_sda = 1'b1;
          open_phase(3'd4, 1'b0);
          return 1'b1;
        end
        m_rx = m_shift;
        return 1'b0;
      end
      i2cbm_pkg::CMD_RECOVER: begin
        if (m_phase == 3'd0) begin
          m_scl = 1'b1;
          open_phase(3'd1, 1'b1);
          return 1'b1;
        end
        if (m_phase == 3'd1) begin
          // Stop pulsing once SDA is free or the ninth pulse has been given.
          if (sda || m_bits >= i2cbm_pkg::LAST_BIT) begin
            m_sda = 1'b0;
            open_phase(3'd2, 1'b0);
            return 1'b1;
          end
          m_bits = m_bits + 4'd1;
          m_scl  = 1'b0;
          open_phase(3'd0, 1'b0);
          return 1'b1;
        end
        if (m_phase == 3'd2) begin
          m_scl = 1'b1;
          open_phase(3'd3, 1'b1);
          return 1'b1;
        end
        if (m_phase == 3'd3) begin
          m_sda = 1'b1;
          open_phase(3'd4, 1'b0);
          return 1'b1;
        end
        return 1'b0;
      end
      default: return 1'b0;
    endcase
  endfunction

  // One bus tick through the model: returns the line state after the tick.
  function automatic i2cbm_pkg::result_t master_tick(input tick_t t);
    logic finished;
    finished = 1'b0;
    if (m_cmd == i2cbm_pkg::CMD_NONE) begin
      if (t.mode >= i2cbm_pkg::CMD_START && t.mode <= i2cbm_pkg::CMD_RECOVER) begin
        m_cmd  = t.mode;
        m_bits = '0;
        case (t.mode)
          i2cbm_pkg::CMD_START: begin
            m_sda = 1'b1;
            m_scl = 1'b1;
            open_phase(3'd0, 1'b1);
          end
          i2cbm_pkg::CMD_STOP: begin
            m_sda = 1'b0;
            m_scl = 1'b0;
            open_phase(3'd0, 1'b0);
          end
          i2cbm_pkg::CMD_SEND: begin
            m_sda   = t.tx[7];
            m_shift = {t.tx[6:0], 1'b0};
            open_phase(3'd0, 1'b0);
          end
          i2cbm_pkg::CMD_READ: begin
            m_nack  = t.nack;
            m_shift = '0;
            m_sda   = 1'b1;
            m_scl   = 1'b1;
            open_phase(3'd0, 1'b1);
          end
          default: begin
            m_sda = 1'b1;
            m_scl = 1'b0;
            open_phase(3'd0, 1'b0);
          end
        endcase
      end
    end else if (m_stretch != '0 && !t.scl) begin
      // A slave is still holding SCL low.
      m_stretch = m_stretch - 16'd1;
    end else begin
      m_stretch = '0;
      if (m_delay > 10'd1) begin
        m_delay = m_delay - 10'd1;
      end else if (!next_phase(t.sda)) begin
        m_cmd    = i2cbm_pkg::CMD_NONE;
        m_phase  = '0;
        m_delay  = '0;
        finished = 1'b1;
      end
    end
    return '{scl_release: m_scl, sda_release: m_sda,
             busy: (m_cmd != i2cbm_pkg::CMD_NONE),
             done: finished, rx_byte: m_rx, ack_missing: m_ack};
  endfunction

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      fail_count++;
    end
  endfunction

  // Watches both channels. An accepted tick is run through the model (or takes
  // its typed-in expectation); an accepted result is compared with the oldest
  // expectation waiting.
  always @(posedge clk) begin : watch
    i2cbm_pkg::result_t predicted;
    i2cbm_pkg::result_t want;
    if (!rst) begin
      if (in_valid && in_ready) begin
        predicted = master_tick('{mode: mode, tx: tx_byte, nack: nack_last,
                                  sda: sda_in, scl: scl_in});
        expected_lines.push_back(lit_on ? lit_want : predicted);
        taken++;
      end
      if (out_valid && out_ready) begin
        if (expected_lines.size() == 0) begin
          $display("%0t: result transaction with nothing expected, got %h", $time,
                   {scl_release, sda_release, busy_res, done_res, rx_byte, ack_missing});
          fail_count++;
        end else begin
          want = expected_lines.pop_front();
          check_field("scl_release", want.scl_release, scl_release);
          check_field("sda_release", want.sda_release, sda_release);
          check_field("busy_res", want.busy, busy_res);
          check_field("done_res", want.done, done_res);
          check_field("rx_byte", want.rx_byte, rx_byte);
          check_field("ack_missing", want.ack_missing, ack_missing);
        end
      end
    end
  end

  // Receiver side. A hold-off asked for by the stimulus keeps out_ready low for a
  // long run of cycles so that the result register fills and in_ready falls;
  // otherwise ready is dropped at random at the phase's stall rate.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_asked != hold_served) begin
      hold_served <= hold_asked;
      hold_left   <= HOLD_CYCLES;
      out_ready   <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Offers one tick and returns at the edge at which the transaction is taken.
  // Called at a rising edge; valid stays high until the handshake completes.
  task automatic drive_tick(input tick_t t, input logic lit,
                            input i2cbm_pkg::result_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    mode      <= t.mode;
    tx_byte   <= t.tx;
    nack_last <= t.nack;
    sda_in    <= t.sda;
    scl_in    <= t.scl;
    lit_on    <= lit;
    lit_want  <= want;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Brings the master back to idle with released-bus ticks, waits for every
  // result to come back and then for the output latency. Sampling is done on
  // the falling edge, where the model and the queue are stable.
  task automatic settle_master();
    in_valid <= 1'b0;
    forever begin
      @(negedge clk);
      if (expected_lines.size() == 0) begin
        if (m_cmd == i2cbm_pkg::CMD_NONE) break;
        @(posedge clk);
        drive_tick(IDLE_TICK, 1'b0, LINES_IDLE);
        in_valid <= 1'b0;
      end
    end
    repeat (SETTLE_PAUSE) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == i2cbm_pkg::REG_DELAY_TICKS) cfg_delay = value[9:0];
    else cfg_stretch = value;
  endtask

  // One command followed by roughly as many ticks as it should take to run,
  // sometimes cut short so that the next command arrives while still busy.
  // The filler ticks now and then carry a stray mode, and SCL is now and then
  // held low by a "slave" for a short stretch.
  task automatic play_command();
    tick_t      t;
    logic [2:0] cmd;
    int         pick;
    int         span;
    int         low_left;
    int         eff_delay;
    pick = $urandom_range(99);
    if (pick < 6) cmd = 3'($urandom_range(7));
    else cmd = 3'(i2cbm_pkg::CMD_START + (pick % 5));
    t = '{mode: cmd, tx: 8'($urandom_range(255)), nack: 1'($urandom_range(1)),
          sda: 1'($urandom_range(1)), scl: ($urandom_range(9) != 0)};
    drive_tick(t, 1'b0, LINES_IDLE);

    eff_delay = (cfg_delay == '0) ? 1 : int'(cfg_delay);
    case (cmd)
      i2cbm_pkg::CMD_SEND:    span = 27 * eff_delay;
      i2cbm_pkg::CMD_READ:    span = 21 * eff_delay;
      i2cbm_pkg::CMD_RECOVER: span = 24 * eff_delay;
      default:                span = 3 * eff_delay;
    endcase
    span = span + $urandom_range(6);
    if ($urandom_range(9) == 0) span = span / 2;
    if (span > 200) span = 200;

    low_left = 0;
    repeat (span) begin
      t.mode = ($urandom_range(9) == 0) ? 3'($urandom_range(7)) : i2cbm_pkg::CMD_NONE;
      t.tx   = 8'($urandom_range(255));
      t.nack = 1'($urandom_range(1));
      // A stuck SDA is what makes recovery pulse; elsewhere SDA is random data.
      if (cmd == i2cbm_pkg::CMD_RECOVER) t.sda = ($urandom_range(7) == 0);
      else t.sda = 1'($urandom_range(1));
      if (low_left > 0) begin
        t.scl = 1'b0;
        low_left--;
      end else if ($urandom_range(99) < 5) begin
        low_left = $urandom_range(12);
        t.scl    = 1'b0;
      end else begin
        t.scl = 1'b1;
      end
      drive_tick(t, 1'b0, LINES_IDLE);
    end
  endtask

  task automatic run_phase(input int delay, input int stretch, input int idle,
                           input int stall, input int items, input bit hold);
    int stop_at;
    settle_master();
    write_reg(i2cbm_pkg::REG_DELAY_TICKS, 16'(delay));
    write_reg(i2cbm_pkg::REG_STRETCH_LIMIT, 16'(stretch));
    send_idle_pct = idle;
    stall_pct <= stall;
    if (hold) hold_asked <= hold_asked + 1;
    stop_at = taken + items;
    while (taken < stop_at) play_command();
  endtask

  initial begin : stimulus
    step_row_t r;
    tick_t     t;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (DIR_STEPS[i]) begin
      r = DIR_STEPS[i];
      if (r.kind == ROW_CFG) begin
        settle_master();
        write_reg(r.cfg_idx, r.cfg_val);
      end else begin
        t = '{mode: r.mode, tx: r.tx, nack: r.nack, sda: r.sda, scl: r.scl};
        repeat (r.reps) drive_tick(t, r.chk, r.want);
      end
    end

    // Random part: the timing registers are moved between phases, the extremes
    // of the stretch limit among them, while the idling pattern of either side
    // changes. The longer delay is kept modest so that draining a command in
    // flight does not swamp the run with filler ticks.
    run_phase(1, 2, 0, 0, 400, 1'b0);
    run_phase(2, 0, 51, 0, 300, 1'b0);
    run_phase(3, 5, 0, 51, 300, 1'b1);
    run_phase(1, 65535, 6, 6, 300, 1'b0);
    run_phase(9, 1, 0, 0, 5, 1'b0);
    run_phase(4, 8, 6, 6, 300, 1'b0);

    in_valid <= 1'b0;
    do @(negedge clk); while (expected_lines.size() != 0);
    repeat (SETTLE_PAUSE) @(posedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin : watchdog
    while (cycles < CYCLE_LIMIT) @(posedge clk);
    $display("== FAIL ==");
    $finish;
  end

endmodule
